[sv/u8dec_pkg.sv]
`default_nettype none
package u8dec_pkg;

    localparam int CpW  = 21;
    localparam int LenW = 3;

    localparam logic [7:0] AsciiLimit = 8'h80;
    localparam logic [7:0] Lead2Mask  = 8'hE0;
    localparam logic [7:0] Lead2Code  = 8'hC0;
    localparam logic [7:0] Lead3Mask  = 8'hF0;
    localparam logic [7:0] Lead3Code  = 8'hE0;
    localparam logic [7:0] Lead4Mask  = 8'hF8;
    localparam logic [7:0] Lead4Code  = 8'hF0;

    typedef struct packed {
        logic [CpW-1:0]  code_point;
        logic [LenW-1:0] char_bytes;
        logic            has_char;
        logic            end_of_text;
        logic            last;
    } t_result;

    // results caused by one input byte
    typedef struct packed {
        logic    any;
        logic    two;
        t_result res0;
        t_result res1;
    } t_pair;

    // sequence length announced by a lead byte, 0 for an invalid lead
    function automatic logic [LenW-1:0] lead_len(input logic [7:0] b);
        logic [LenW-1:0] len;
        len = 3'd0;
        if (b < AsciiLimit) begin
            len = 3'd1;
        end else if ((b & Lead2Mask) == Lead2Code) begin
            len = 3'd2;
        end else if ((b & Lead3Mask) == Lead3Code) begin
            len = 3'd3;
        end else if ((b & Lead4Mask) == Lead4Code) begin
            len = 3'd4;
        end
        return len;
    endfunction

endpackage
`default_nettype wire

[sv/u8dec_decode.sv]
`default_nettype none
module u8dec_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_byte_in,
    input  wire logic            i_text_end,
    output u8dec_pkg::t_pair     o_pair
);
    import u8dec_pkg::*;

    logic [7:0]      r_held0, r_held1, r_held2;
    logic [1:0]      r_count;
    logic [LenW-1:0] r_exp;
    logic [7:0]      n_held0, n_held1, n_held2;
    logic [1:0]      n_count;
    logic [LenW-1:0] n_exp;

    logic [LenW-1:0] len_b, len_h1;
    logic            complete;
    logic [CpW-1:0]  cp_done;
    logic            v0, v1;
    logic [CpW-1:0]  cp0, cp1;
    logic [LenW-1:0] bytes0, bytes1;

    assign len_b    = lead_len(i_byte_in);
    assign len_h1   = lead_len(r_held1);
    assign complete = (r_count != 2'd0) && (({1'b0, r_count} + 3'd1) == r_exp);

    always_comb begin
        case (r_exp)
            3'd2:    cp_done = {10'd0, r_held0[4:0], i_byte_in[5:0]};
            3'd3:    cp_done = {5'd0, r_held0[3:0], r_held1[5:0], i_byte_in[5:0]};
            3'd4:    cp_done = {r_held0[2:0], r_held1[5:0], r_held2[5:0], i_byte_in[5:0]};
            default: cp_done = '0;
        endcase
    end

    always_comb begin
        v0     = 1'b0;
        v1     = 1'b0;
        cp0    = '0;
        cp1    = '0;
        bytes0 = '0;
        bytes1 = '0;
        if (r_count == 2'd0) begin
            if (len_b == 3'd1) begin
                v0     = 1'b1;
                cp0    = {13'd0, i_byte_in};
                bytes0 = 3'd1;
            end
        end else if (complete) begin
            v0     = 1'b1;
            cp0    = cp_done;
            bytes0 = r_exp;
        end else if (i_text_end) begin
            // truncated sequence: lead dropped, later bytes rescanned as starts
            if (r_count == 2'd1) begin
                if (len_b == 3'd1) begin
                    v0     = 1'b1;
                    cp0    = {13'd0, i_byte_in};
                    bytes0 = 3'd1;
                end
            end else if (len_h1 == 3'd1) begin
                v0     = 1'b1;
                cp0    = {13'd0, r_held1};
                bytes0 = 3'd1;
                if (len_b == 3'd1) begin
                    v1     = 1'b1;
                    cp1    = {13'd0, i_byte_in};
                    bytes1 = 3'd1;
                end
            end else if (len_h1 == 3'd2) begin
                v0     = 1'b1;
                cp0    = {10'd0, r_held1[4:0], i_byte_in[5:0]};
                bytes0 = 3'd2;
            end else if (len_b == 3'd1) begin
                v0     = 1'b1;
                cp0    = {13'd0, i_byte_in};
                bytes0 = 3'd1;
            end
        end
        // final byte always yields at least one result, possibly empty
        if (i_text_end && !v0) begin
            v0 = 1'b1;
        end
    end

    always_comb begin
        o_pair.any              = v0;
        o_pair.two              = v1;
        o_pair.res0.code_point  = cp0;
        o_pair.res0.char_bytes  = bytes0;
        o_pair.res0.has_char    = bytes0 != 3'd0;
        o_pair.res0.last        = !v1;
        o_pair.res0.end_of_text = i_text_end && !v1;
        o_pair.res1.code_point  = cp1;
        o_pair.res1.char_bytes  = bytes1;
        o_pair.res1.has_char    = bytes1 != 3'd0;
        o_pair.res1.last        = 1'b1;
        o_pair.res1.end_of_text = i_text_end;
    end

    always_comb begin
        n_held0 = r_held0;
        n_held1 = r_held1;
        n_held2 = r_held2;
        n_count = r_count;
        n_exp   = r_exp;
        if (r_count == 2'd0) begin
            if ((len_b >= 3'd2) && !i_text_end) begin
                n_held0 = i_byte_in;
                n_count = 2'd1;
                n_exp   = len_b;
            end
        end else if (complete || i_text_end) begin
            n_count = 2'd0;
            n_exp   = 3'd0;
        end else begin
            case (r_count)
                2'd1:    n_held1 = i_byte_in;
                default: n_held2 = i_byte_in;
            endcase
            n_count = r_count + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_exp   <= 3'd0;
            r_held0 <= 8'd0;
            r_held1 <= 8'd0;
            r_held2 <= 8'd0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_exp   <= n_exp;
            r_held0 <= n_held0;
            r_held1 <= n_held1;
            r_held2 <= n_held2;
        end
    end

endmodule
`default_nettype wire

[sv/utf8_byte_decoder.sv]
// a result passes from its byte transfer through the result buffer into the output register
// throughput: one byte per cycle while the output is not stalled; a byte that yields two
// results stalls the input while the second result leaves the result buffer
// reset: synchronous active-low i_rst_n clears the open sequence and empties
// the result buffer and output register
`default_nettype none
module utf8_byte_decoder (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [7:0]                     i_byte_in,
    input  wire logic                           i_text_end,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [u8dec_pkg::CpW-1:0]           o_code_point,
    output logic [u8dec_pkg::LenW-1:0]          o_char_bytes,
    output logic                                o_has_char,
    output logic                                o_end_of_text,
    output logic                                o_last
);
    import u8dec_pkg::*;

    t_pair   dec_pair;
    logic    in_xfer;
    logic    out_load, pair_move, pair_drain;
    t_result cur_res;

    logic    r_pv, r_ptwo, r_pidx;
    t_result r_res0, r_res1;
    logic    r_ov;
    t_result r_out;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_load   = !r_ov || !i_out_stall;
    assign pair_move  = r_pv && out_load;
    assign pair_drain = pair_move && (r_pidx || !r_ptwo);
    assign o_in_stall = r_pv && !pair_drain;
    assign cur_res    = r_pidx ? r_res1 : r_res0;

    u8dec_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_xfer),
        .i_byte_in  (i_byte_in),
        .i_text_end (i_text_end),
        .o_pair     (dec_pair)
    );

    // result buffer: holds the one or two results of the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_ptwo <= 1'b0;
            r_pidx <= 1'b0;
        end else if (in_xfer && dec_pair.any) begin
            r_pv   <= 1'b1;
            r_ptwo <= dec_pair.two;
            r_pidx <= 1'b0;
        end else if (pair_drain) begin
            r_pv   <= 1'b0;
            r_pidx <= 1'b0;
        end else if (pair_move) begin
            r_pidx <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && dec_pair.any) begin
            r_res0 <= dec_pair.res0;
            r_res1 <= dec_pair.res1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= pair_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= cur_res;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_code_point  = r_out.code_point;
    assign o_char_bytes  = r_out.char_bytes;
    assign o_has_char    = r_out.has_char;
    assign o_end_of_text = r_out.end_of_text;
    assign o_last        = r_out.last;

    a_second_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pidx |-> (r_pv && r_ptwo))
        else $error("second result selected without a second result");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_text_end) |=> r_pv)
        else $error("final byte produced no result");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pv |-> !o_in_stall)
        else $error("input stalled with empty result buffer");

    a_out_last_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pair_move && !pair_drain) |=> (r_pv && r_pidx))
        else $error("result buffer lost its second result");

endmodule
`default_nettype wire

[test/tb_utf8_byte_decoder.sv]
`default_nettype none
module tb_utf8_byte_decoder;
    import u8dec_pkg::*;

    localparam int StimItems  = 1550;
    localparam int CycleLimit = 100000;
    localparam int HoldCycles = 120;

    typedef struct packed {
        logic [7:0] b;
        logic       te;
    } t_byte_xfer;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_stall;
    logic [7:0]      i_byte_in = 8'h00;
    logic            i_text_end = 1'b0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    logic [CpW-1:0]  o_code_point;
    logic [LenW-1:0] o_char_bytes;
    logic            o_has_char;
    logic            o_end_of_text;
    logic            o_last;

    utf8_byte_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_byte_in     (i_byte_in),
        .i_text_end    (i_text_end),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_code_point  (o_code_point),
        .o_char_bytes  (o_char_bytes),
        .o_has_char    (o_has_char),
        .o_end_of_text (o_end_of_text),
        .o_last        (o_last)
    );

    t_byte_xfer byte_q[$];
    t_result    char_q[$];
    int         stim_total = 0;
    int         accepted_count = 0;
    int         err_count = 0;
    int         cycles = 0;
    int         hold_left = 0;
    logic       hold_used = 1'b0;
    int         run_phase;
    int         send_idle_pct;
    int         recv_stall_pct;

    // decoder state as seen by the predictor
    logic [7:0] held [0:2] = '{8'h00, 8'h00, 8'h00};
    logic [1:0] held_cnt = 2'd0;
    logic [2:0] want_len = 3'd0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // four idling phases over the run
    always_comb begin
        run_phase = (stim_total == 0) ? 0 : (accepted_count * 4) / stim_total;
        send_idle_pct  = (run_phase == 1) ? 53 : (run_phase == 3) ? 26 : 0;
        recv_stall_pct = (run_phase == 2) ? 53 : (run_phase == 3) ? 26 : 0;
    end

    function automatic int seq_length(input logic [7:0] b);
        if (b < AsciiLimit) return 1;
        if ((b & Lead2Mask) == Lead2Code) return 2;
        if ((b & Lead3Mask) == Lead3Code) return 3;
        if ((b & Lead4Mask) == Lead4Code) return 4;
        return 0;
    endfunction

    function automatic logic [20:0] pack_code_point(input logic [7:0] b0, input logic [7:0] b1,
                                                    input logic [7:0] b2, input logic [7:0] b3,
                                                    input int len);
        case (len)
            1: return {13'd0, b0};
            2: return {10'd0, b0[4:0], b1[5:0]};
            3: return {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            4: return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: return 21'd0;
        endcase
    endfunction

    task automatic clear_seq();
        held[0] = 8'h00;
        held[1] = 8'h00;
        held[2] = 8'h00;
        held_cnt = 2'd0;
        want_len = 3'd0;
    endtask

    // advance the decoder state by one byte and queue the characters it yields
    task automatic decode_byte(input logic [7:0] b, input logic te);
        logic [7:0]  seq [0:6];
        logic [20:0] cps [0:1];
        logic [2:0]  lens [0:1];
        int          n;
        int          cnt;
        int          total;
        int          pos;
        int          len;
        int          k;
        t_result     r;
        n = 0;
        cps[0] = 21'd0;
        cps[1] = 21'd0;
        lens[0] = 3'd0;
        lens[1] = 3'd0;
        for (k = 0; k < 7; k++) seq[k] = 8'h00;
        if (held_cnt == 2'd0) begin
            len = seq_length(b);
            if (len == 1) begin
                cps[0] = {13'd0, b};
                lens[0] = 3'd1;
                n = 1;
            end else if (len >= 2 && !te) begin
                held[0] = b;
                held_cnt = 2'd1;
                want_len = len[2:0];
            end
        end else begin
            cnt = held_cnt;
            for (k = 0; k < cnt; k++) seq[k] = held[k];
            seq[cnt] = b;
            total = cnt + 1;
            if (total >= want_len) begin
                len = want_len;
                cps[0] = pack_code_point(seq[0], seq[1], seq[2], seq[3], len);
                lens[0] = len[2:0];
                n = 1;
                clear_seq();
            end else if (te) begin
                // lead dropped, rest rescanned as fresh starts
                pos = 1;
                while (pos < total && n < 2) begin
                    len = seq_length(seq[pos]);
                    if (len == 0 || pos + len > total) begin
                        pos++;
                    end else begin
                        cps[n] = pack_code_point(seq[pos], seq[pos+1], seq[pos+2], seq[pos+3],
                                                 len);
                        lens[n] = len[2:0];
                        n++;
                        pos += len;
                    end
                end
                clear_seq();
            end else if (cnt < 3) begin
                held[cnt] = b;
                held_cnt = held_cnt + 2'd1;
            end
        end
        if (te) begin
            if (n == 0) n = 1;
            clear_seq();
        end
        for (k = 0; k < n; k++) begin
            r.has_char    = (lens[k] != 3'd0);
            r.code_point  = r.has_char ? cps[k] : 21'd0;
            r.char_bytes  = lens[k];
            r.end_of_text = te && (k == n - 1);
            r.last        = (k == n - 1);
            char_q.insert(char_q.size(), r);
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic te);
        t_byte_xfer x;
        x.b = b;
        x.te = te;
        byte_q.insert(byte_q.size(), x);
    endtask

    function automatic logic [7:0] make_lead(input int len);
        case (len)
            1: return {1'b0, 7'($urandom_range(127))};
            2: return {3'b110, 5'($urandom_range(31))};
            3: return {4'b1110, 4'($urandom_range(15))};
            default: return {5'b11110, 3'($urandom_range(7))};
        endcase
    endfunction

    // stimulus build and end of run
    initial begin
        int          r;
        int          len;
        int          m;
        int          k;
        logic [7:0]  fill;
        logic        ends;
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hC2, 1'b0);
        push_byte(8'hA9, 1'b0);
        push_byte(8'hE2, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'hAC, 1'b0);
        // largest code point the masks allow
        push_byte(8'hF7, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b1);
        // invalid leads
        push_byte(8'h80, 1'b0);
        push_byte(8'hF8, 1'b0);
        // ascii swallowed as a continuation
        push_byte(8'hC3, 1'b0);
        push_byte(8'h41, 1'b0);
        // text ends mid sequence: one rescanned character
        push_byte(8'hF0, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'hA9, 1'b1);
        // text ends mid sequence: two rescanned characters
        push_byte(8'hF0, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b1);
        // lead as final byte, then empty final result
        push_byte(8'hE2, 1'b1);
        push_byte(8'h80, 1'b1);

        while (byte_q.size() < StimItems) begin
            r = $urandom_range(99);
            if (r < 8) begin
                push_byte(8'($urandom_range(255)), ($urandom_range(15) == 0));
            end else if (r < 16) begin
                // truncated sequence closed by the end of text
                len = $urandom_range(2, 4);
                m = $urandom_range(len - 2);
                push_byte(make_lead(len), (m == 0));
                for (k = 0; k < m; k++) begin
                    case ($urandom_range(2))
                        0: fill = make_lead(1);
                        1: fill = make_lead($urandom_range(2, 4));
                        default: fill = 8'($urandom_range(255));
                    endcase
                    push_byte(fill, (k == m - 1));
                end
            end else begin
                len = $urandom_range(1, 4);
                ends = ($urandom_range(9) == 0);
                push_byte(make_lead(len), ends && len == 1);
                for (k = 1; k < len; k++) begin
                    fill = ($urandom_range(15) == 0) ? 8'($urandom_range(255))
                                                     : {2'b10, 6'($urandom_range(63))};
                    push_byte(fill, ends && k == len - 1);
                end
            end
        end
        stim_total = byte_q.size();

        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        while (byte_q.size() != 0 || i_in_valid) @(negedge i_clk);
        while (char_q.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
        if (err_count == 0) begin
            $display("utf8_byte_decoder verification clean");
        end else begin
            $display("utf8_byte_decoder verification failed");
        end
        $finish;
    end

    // byte sender
    always @(posedge i_clk) begin : feed
        t_byte_xfer nxt;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                decode_byte(i_byte_in, i_text_end);
                accepted_count <= accepted_count + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = byte_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_byte_in  <= nxt.b;
                    i_text_end <= nxt.te;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // one long hold-off early on so the decoder backs up into its input
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && stim_total != 0 && accepted_count >= stim_total / 8) begin
            hold_left <= HoldCycles;
            hold_used <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin : check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (char_q.size() == 0) begin
                $display("%0t unexpected transfer: code_point %h char_bytes %0d", $time,
                         o_code_point, o_char_bytes);
                err_count++;
            end else begin
                want = char_q.pop_front();
                if (o_code_point !== want.code_point) begin
                    $display("%0t code_point expected %h got %h", $time, want.code_point,
                             o_code_point);
                    err_count++;
                end
                if (o_char_bytes !== want.char_bytes) begin
                    $display("%0t char_bytes expected %0d got %0d", $time, want.char_bytes,
                             o_char_bytes);
                    err_count++;
                end
                if (o_has_char !== want.has_char) begin
                    $display("%0t has_char expected %b got %b", $time, want.has_char,
                             o_has_char);
                    err_count++;
                end
                if (o_end_of_text !== want.end_of_text) begin
                    $display("%0t end_of_text expected %b got %b", $time, want.end_of_text,
                             o_end_of_text);
                    err_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t last expected %b got %b", $time, want.last, o_last);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("utf8_byte_decoder verification failed");
            $finish;
        end
    end

endmodule
`default_nettype wire
